FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the checker file rpd_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define RPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define RPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// Types and constants of the raster packet deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

    localparam int unsigned ROW_COUNT_W   = 10;
    localparam int unsigned ROW_BYTES_W   = 11;
    localparam int unsigned POS_W         = 11;
    localparam int unsigned VALUE_W       = 22;
    localparam int unsigned MAX_RESULTS   = 3;
    localparam int unsigned RES_IDX_W     = 2;

    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_LIMIT_RST = 10'd464;
    localparam logic [ROW_BYTES_W-1:0] ROW_BYTE_LIMIT_RST  = 11'd920;
    localparam logic [15:0]            CODE_A              = 16'hBA0F;
    localparam logic [15:0]            CODE_B              = 16'hBA07;
    localparam logic [POS_W:0]         HEADER_BYTES        = 12'd22;
    localparam logic [POS_W-1:0]       ROW_COUNT_FIELD     = 11'd8;
    localparam logic [POS_W-1:0]       CODE_FIELD          = 11'd0;

    typedef enum logic [0:0] {
        CFG_ROW_COUNT_LIMIT = 1'b0,
        CFG_ROW_BYTE_LIMIT  = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LEN    = 2'd1,
        PH_DATA   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_CODE  = 3'd1,
        ST_BAD_ROWS  = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_TRUNCATED = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]             kind;
        logic [3:0]             field_index;
        logic [VALUE_W-1:0]     value;
        logic [ROW_COUNT_W-1:0] row_index;
        logic                   row_end;
        logic [2:0]             status;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic [RES_IDX_W-1:0]        cnt;
        t_result [MAX_RESULTS-1:0]   res;
    } t_bundle;

    typedef struct packed {
        logic [ROW_COUNT_W-1:0] row_count_limit;
        logic [ROW_BYTES_W-1:0] row_byte_limit;
    } t_cfg;

endpackage

FILE: hw/rtl/rpd_cfg.sv
// ----------------------------------------------------------------------------
// rpd_cfg
// Configuration registers: row count limit and row byte limit.
// ----------------------------------------------------------------------------
module rpd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [rpd_pkg::ROW_BYTES_W-1:0] i_cfg_data,
    output rpd_pkg::t_cfg                 o_cfg
);
    import rpd_pkg::*;

    logic [ROW_COUNT_W-1:0] r_row_count_limit;
    logic [ROW_BYTES_W-1:0] r_row_byte_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count_limit <= ROW_COUNT_LIMIT_RST;
            r_row_byte_limit  <= ROW_BYTE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ROW_COUNT_LIMIT: r_row_count_limit <= i_cfg_data[ROW_COUNT_W-1:0];
                CFG_ROW_BYTE_LIMIT:  r_row_byte_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.row_count_limit = r_row_count_limit;
    assign o_cfg.row_byte_limit  = r_row_byte_limit;

endmodule

FILE: hw/rtl/rpd_core.sv
// ----------------------------------------------------------------------------
// rpd_core
// Packet state and the per-byte step: header words, row lengths, row data
// with one byte of delay, and the closing status.
// ----------------------------------------------------------------------------
module rpd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_data_byte,
    input  logic            i_stream_end,
    input  rpd_pkg::t_cfg   i_cfg,
    output rpd_pkg::t_bundle o_bundle
);
    import rpd_pkg::*;

    t_phase                 r_phase,       n_phase;
    logic [POS_W-1:0]       r_pos,         n_pos;
    logic [7:0]             r_high,        n_high;
    logic [15:0]            r_hdr_rows,    n_hdr_rows;
    logic [2:0]             r_hdr_err,     n_hdr_err;
    logic [ROW_COUNT_W-1:0] r_row,         n_row;
    logic [15:0]            r_row_len,     n_row_len;
    logic [7:0]             r_held,        n_held;
    logic                   r_held_valid,  n_held_valid;
    logic [VALUE_W-1:0]     r_total,       n_total;

    logic [15:0]      word;
    logic [POS_W:0]   pos1;
    logic             len_bad;
    logic             data_last;
    logic             row_last;
    logic             hdr_last;
    logic [2:0]       hdr_err_upd;
    logic             done;
    t_status          st;

    assign word      = {r_high, i_data_byte};
    assign pos1      = {1'b0, r_pos} + 1'b1;
    assign n_total   = r_total + 1'b1;
    assign len_bad   = word[0] || (word < 16'd2) ||
                       (word > {{(16-ROW_BYTES_W){1'b0}}, i_cfg.row_byte_limit});
    assign data_last = {{(16-POS_W-1){1'b0}}, pos1} >= r_row_len;
    assign row_last  = ({{(17-ROW_COUNT_W){1'b0}}, r_row} + 17'd1) >= {1'b0, r_hdr_rows};
    assign hdr_last  = pos1 >= HEADER_BYTES;

    always_comb begin
        hdr_err_upd = r_hdr_err;
        if (r_pos[0]) begin
            if ((r_pos[POS_W-1:1] == CODE_FIELD[POS_W-1:1]) && (word != CODE_A) &&
                (word != CODE_B)) begin
                hdr_err_upd = ST_BAD_CODE;
            end
            if ((r_pos[POS_W-1:1] == ROW_COUNT_FIELD[POS_W-2:0]) && (hdr_err_upd == ST_OK) &&
                ((word < 16'd1) ||
                 (word > {{(16-ROW_COUNT_W){1'b0}}, i_cfg.row_count_limit}))) begin
                hdr_err_upd = ST_BAD_ROWS;
            end
        end
    end

    // Decide whether this byte closes the packet, and with which status.
    always_comb begin
        done = 1'b0;
        st   = ST_OK;
        unique case (r_phase)
            PH_LEN: begin
                if (r_pos == '0) begin
                    if (i_stream_end) begin
                        done = 1'b1;
                        st   = ST_TRUNCATED;
                    end
                end else if (len_bad) begin
                    done = 1'b1;
                    st   = ST_BAD_LEN;
                end else if (i_stream_end) begin
                    done = 1'b1;
                    st   = ST_TRUNCATED;
                end
            end
            PH_DATA: begin
                if (data_last && row_last) begin
                    done = 1'b1;
                    st   = ST_OK;
                end else if (i_stream_end) begin
                    done = 1'b1;
                    st   = ST_TRUNCATED;
                end
            end
            default: begin
                if (hdr_last && (hdr_err_upd != ST_OK)) begin
                    done = 1'b1;
                    st   = t_status'(hdr_err_upd);
                end else if (i_stream_end) begin
                    done = 1'b1;
                    st   = ST_TRUNCATED;
                end
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_high       = r_high;
        n_hdr_rows   = r_hdr_rows;
        n_hdr_err    = r_hdr_err;
        n_row        = r_row;
        n_row_len    = r_row_len;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        unique case (r_phase)
            PH_LEN: begin
                if (r_pos == '0) begin
                    n_high = i_data_byte;
                    n_pos  = POS_W'(1);
                end else begin
                    n_row_len = word;
                    if (!len_bad && !i_stream_end) begin
                        n_phase      = PH_DATA;
                        n_pos        = '0;
                        n_held_valid = 1'b0;
                    end
                end
            end
            PH_DATA: begin
                if (data_last) begin
                    n_held_valid = 1'b0;
                    if (!row_last) begin
                        n_row   = r_row + 1'b1;
                        n_phase = PH_LEN;
                        n_pos   = '0;
                    end
                end else begin
                    n_held       = i_data_byte;
                    n_held_valid = 1'b1;
                    n_pos        = pos1[POS_W-1:0];
                end
            end
            default: begin
                if (!r_pos[0]) begin
                    n_high = i_data_byte;
                end else if (r_pos[POS_W-1:1] == ROW_COUNT_FIELD[POS_W-2:0]) begin
                    n_hdr_rows = word;
                end
                n_hdr_err = hdr_err_upd;
                if (hdr_last) begin
                    n_phase = PH_LEN;
                    n_pos   = '0;
                    n_row   = '0;
                end else begin
                    n_pos = pos1[POS_W-1:0];
                end
            end
        endcase
    end

    // Results of this byte.
    always_comb begin
        t_result              res_v;
        logic [RES_IDX_W-1:0] n_res;
        res_v = '0;
        n_res = '0;
        o_bundle = '0;
        unique case (r_phase)
            PH_LEN: ;
            PH_DATA: begin
                if (r_held_valid) begin
                    res_v           = '0;
                    res_v.kind      = KIND_DATA;
                    res_v.value     = {{(VALUE_W-8){1'b0}}, r_held};
                    res_v.row_index = r_row;
                    res_v.row_end   = data_last && (i_data_byte == 8'd0);
                    o_bundle.res[n_res] = res_v;
                    n_res = n_res + 1'b1;
                end
                if (data_last && (i_data_byte != 8'd0)) begin
                    res_v           = '0;
                    res_v.kind      = KIND_DATA;
                    res_v.value     = {{(VALUE_W-8){1'b0}}, i_data_byte};
                    res_v.row_index = r_row;
                    res_v.row_end   = 1'b1;
                    o_bundle.res[n_res] = res_v;
                    n_res = n_res + 1'b1;
                end
            end
            default: begin
                if (r_pos[0]) begin
                    res_v             = '0;
                    res_v.kind        = KIND_HEADER;
                    res_v.field_index = r_pos[4:1];
                    res_v.value       = {{(VALUE_W-16){1'b0}}, word};
                    o_bundle.res[n_res] = res_v;
                    n_res = n_res + 1'b1;
                end
            end
        endcase
        if (done) begin
            res_v        = '0;
            res_v.kind   = KIND_STATUS;
            res_v.value  = n_total;
            res_v.status = st;
            o_bundle.res[n_res] = res_v;
            n_res = n_res + 1'b1;
        end
        if (n_res != '0) begin
            o_bundle.res[n_res - 1'b1].last = 1'b1;
        end
        o_bundle.cnt = n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_pos        <= '0;
            r_high       <= '0;
            r_hdr_rows   <= '0;
            r_hdr_err    <= '0;
            r_row        <= '0;
            r_row_len    <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_total      <= '0;
        end else if (i_step) begin
            if (done) begin
                r_phase      <= PH_HEADER;
                r_pos        <= '0;
                r_high       <= '0;
                r_hdr_rows   <= '0;
                r_hdr_err    <= '0;
                r_row        <= '0;
                r_row_len    <= '0;
                r_held       <= '0;
                r_held_valid <= 1'b0;
                r_total      <= '0;
            end else begin
                r_phase      <= n_phase;
                r_pos        <= n_pos;
                r_high       <= n_high;
                r_hdr_rows   <= n_hdr_rows;
                r_hdr_err    <= n_hdr_err;
                r_row        <= n_row;
                r_row_len    <= n_row_len;
                r_held       <= n_held;
                r_held_valid <= n_held_valid;
                r_total      <= n_total;
            end
        end
    end

endmodule

FILE: hw/rtl/rpd_out.sv
// ----------------------------------------------------------------------------
// rpd_out
// Result register: holds the results of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module rpd_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rpd_pkg::t_bundle i_bundle,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output rpd_pkg::t_result o_result,
    output logic             o_free
);
    import rpd_pkg::*;

    logic [RES_IDX_W-1:0]      r_cnt;
    logic [RES_IDX_W-1:0]      r_idx;
    t_result [MAX_RESULTS-1:0] r_res;
    logic                      pop;
    logic                      pop_last;

    assign o_out_valid = (r_cnt != '0);
    assign o_result    = r_res[r_idx];
    assign pop         = o_out_valid && !i_out_stall;
    assign pop_last    = pop && ((r_idx + 1'b1) == r_cnt);
    assign o_free      = !o_out_valid || pop_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_bundle.cnt;
            r_idx <= '0;
        end else if (pop_last) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (pop) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_bundle.res;
        end
    end

endmodule

FILE: hw/rtl/raster_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// raster_packet_deframer_top
// Byte-serial deframer for a raster data packet: header words, row data
// with a trailing zero byte dropped, and a closing status per packet.
//
//   channel  direction  handshake                   payload
//   in       sink       i_in_valid / o_in_stall     data_byte, stream_end
//   out      source     o_out_valid / i_out_stall   kind .. last
//   cfg      sink       i_cfg_valid / o_cfg_ready   cfg_index, cfg_data
//
// One byte is taken per cycle while the result register is free; the byte
// is held in the input register and its results in the result register,
// which stays busy until the last result of the byte is handed out.
// Reset is synchronous and returns the deframer to the start of a packet.
// A stall on the output holds the result register and then the input.
// ----------------------------------------------------------------------------
module raster_packet_deframer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_stream_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_kind,
    output logic [3:0]                      o_field_index,
    output logic [rpd_pkg::VALUE_W-1:0]     o_value,
    output logic [rpd_pkg::ROW_COUNT_W-1:0] o_row_index,
    output logic                            o_row_end,
    output logic [2:0]                      o_status,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [rpd_pkg::ROW_BYTES_W-1:0] i_cfg_data
);
    import rpd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       out_free;
    logic       consume;
    logic       accept;
    t_cfg       cfg;
    t_bundle    bundle;
    t_result    result;

    assign consume    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_stream_end;
        end
    end

    rpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rpd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (consume),
        .i_data_byte  (r_in_byte),
        .i_stream_end (r_in_end),
        .i_cfg        (cfg),
        .o_bundle     (bundle)
    );

    rpd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (consume),
        .i_bundle    (bundle),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result),
        .o_free      (out_free)
    );

    assign o_kind        = result.kind;
    assign o_field_index = result.field_index;
    assign o_value       = result.value;
    assign o_row_index   = result.row_index;
    assign o_row_end     = result.row_end;
    assign o_status      = result.status;
    assign o_last        = result.last;

endmodule

FILE: hw/rtl/rpd_checker.sv
// ----------------------------------------------------------------------------
// rpd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [1:0]                      o_kind,
    input logic [3:0]                      o_field_index,
    input logic [rpd_pkg::ROW_COUNT_W-1:0] o_row_index,
    input logic                            o_row_end,
    input logic [2:0]                      o_status,
    input logic                            o_last
);
    import rpd_pkg::*;

    logic out_status;
    logic out_header;
    logic hdr_clean;

    assign out_status = o_out_valid && (o_kind == KIND_STATUS);
    assign out_header = o_out_valid && (o_kind == KIND_HEADER);
    assign hdr_clean  = (o_row_index == '0) && !o_row_end && (o_field_index <= 4'd10);

    `RPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `RPD_ASSERT(a_status_last, i_clk, i_rst_n, !out_status || o_last)
    `RPD_ASSERT(a_status_zero, i_clk, i_rst_n, !o_out_valid || out_status || (o_status == ST_OK))
    `RPD_ASSERT(a_header_clean, i_clk, i_rst_n, !out_header || hdr_clean)

endmodule

bind raster_packet_deframer_top rpd_checker u_rpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kind        (o_kind),
    .o_field_index (o_field_index),
    .o_row_index   (o_row_index),
    .o_row_end     (o_row_end),
    .o_status      (o_status),
    .o_last        (o_last)
);
